// ===== rtl/core/pcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_pkg - shared types and constants
// Register codes, sequencer strobes, the channel write bundle and the
// length counter load table for the pulse channel block.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int CH_SLOTS = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [4:0] FRAME_REG = 5'd23;

    localparam logic [1:0] REG_CONTROL   = 2'd0;
    localparam logic [1:0] REG_SWEEP     = 2'd1;
    localparam logic [1:0] REG_PERIOD_LO = 2'd2;
    localparam logic [1:0] REG_LENGTH    = 2'd3;

    localparam logic [15:0] MIN_PERIOD   = 16'd8;
    localparam logic [3:0]  ENV_FULL     = 4'd15;

    // control byte: DDLC VVVV
    localparam int CTRL_HALT_BIT = 5;
    // sweep byte: EPPP NSSS
    localparam int SWEEP_EN_BIT  = 7;
    localparam int SWEEP_NEG_BIT = 3;

    typedef struct packed {
        logic len_sweep;
        logic envelope;
    } pcs_clk_t;

    typedef struct packed {
        logic       en;
        logic [1:0] sel;
        logic [7:0] data;
    } pcs_wr_t;

    function automatic logic [7:0] length_lookup(input logic [4:0] idx);
        logic [7:0] val;
        unique case (idx)
            5'd0:  val = 8'h0A;
            5'd1:  val = 8'hFE;
            5'd2:  val = 8'h14;
            5'd3:  val = 8'h02;
            5'd4:  val = 8'h28;
            5'd5:  val = 8'h04;
            5'd6:  val = 8'h50;
            5'd7:  val = 8'h06;
            5'd8:  val = 8'hA0;
            5'd9:  val = 8'h08;
            5'd10: val = 8'h3C;
            5'd11: val = 8'h0A;
            5'd12: val = 8'h0E;
            5'd13: val = 8'h0C;
            5'd14: val = 8'h1A;
            5'd15: val = 8'h0E;
            5'd16: val = 8'h0C;
            5'd17: val = 8'h10;
            5'd18: val = 8'h18;
            5'd19: val = 8'h12;
            5'd20: val = 8'h30;
            5'd21: val = 8'h14;
            5'd22: val = 8'h60;
            5'd23: val = 8'h16;
            5'd24: val = 8'hC0;
            5'd25: val = 8'h18;
            5'd26: val = 8'h48;
            5'd27: val = 8'h1A;
            5'd28: val = 8'h10;
            5'd29: val = 8'h1C;
            5'd30: val = 8'h20;
            default: val = 8'h1E;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/pcs_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_cmd_if - command channel
// Valid/ready channel carrying one register write or sequencer tick per item.
// ----------------------------------------------------------------------------
interface pcs_cmd_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [4:0] reg_index;
    logic [7:0] write_data;

    modport source (output valid, output op, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input op, input reg_index, input write_data,
                    output ready);
endinterface

// ===== rtl/core/pcs_status_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_status_if - status channel
// Valid/ready channel carrying the state of both pulse channels per item.
// ----------------------------------------------------------------------------
interface pcs_status_if;
    logic        valid;
    logic        ready;
    logic [15:0] ch1_period;
    logic [7:0]  ch1_length;
    logic [3:0]  ch1_envelope;
    logic [7:0]  ch1_control;
    logic [15:0] ch2_period;
    logic [7:0]  ch2_length;
    logic [3:0]  ch2_envelope;
    logic [7:0]  ch2_control;

    modport source (output valid,
                    output ch1_period, output ch1_length, output ch1_envelope,
                    output ch1_control,
                    output ch2_period, output ch2_length, output ch2_envelope,
                    output ch2_control,
                    input ready);
    modport sink   (input valid,
                    input ch1_period, input ch1_length, input ch1_envelope,
                    input ch1_control,
                    input ch2_period, input ch2_length, input ch2_envelope,
                    input ch2_control,
                    output ready);
endinterface

// ===== rtl/core/pulse_channel_sweep_envelope_length.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_channel_sweep_envelope_length - dual pulse channel with frame sequencer
// Register writes and sequencer ticks update two square-wave channels; each
// item returns both channels' period, length, envelope and control.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   handshake
//  cmd       in   op, reg_index, write_data                 valid/ready
//  status    out  ch1/ch2 period, length, envelope, control valid/ready
//
//  One item per cycle while status is not stalled; an item moves from the
//  input register into channel state, which doubles as the result register.
//  Reset clears all channel and sequencer state; no clearing pass.
//  A stalled status holds the channel state; cmd stays ready while the input
//  register is free or moving into the state in the same cycle.
// ----------------------------------------------------------------------------
module pulse_channel_sweep_envelope_length #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    pcs_cmd_if.sink      cmd,
    pcs_status_if.source status
);
    import pcs_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic       op_reg;
    logic [4:0] idx_reg;
    logic [7:0] data_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       advance;
    logic       cmd_take;
    pcs_clk_t   strobe;

    logic [15:0] period_w   [CH_SLOTS];
    logic [7:0]  length_w   [CH_SLOTS];
    logic [3:0]  envelope_w [CH_SLOTS];
    logic [7:0]  control_w  [CH_SLOTS];

    assign advance   = in_valid_reg && (!out_valid_reg || status.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (cmd_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        if (advance)
            out_valid_next = 1'b1;
        else if (status.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            op_reg   <= cmd.op;
            idx_reg  <= cmd.reg_index;
            data_reg <= cmd.write_data;
        end
    end

    pcs_frame_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .op         (op_reg),
        .reg_index  (idx_reg),
        .write_data (data_reg),
        .strobe     (strobe)
    );

    for (genvar g = 0; g < CH_SLOTS; g++)
    begin : g_chan
        if (g < NUM_CHANNELS)
        begin : g_on
            pcs_wr_t wr;

            assign wr.en   = (op_reg == OP_WRITE) && (idx_reg[4:3] == 2'b00)
                             && (idx_reg[2] == 1'(g));
            assign wr.sel  = idx_reg[1:0];
            assign wr.data = data_reg;

            pcs_chan u_chan (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .neg_extra (g == 0),
                .wr        (wr),
                .strobe    (strobe),
                .period    (period_w[g]),
                .length    (length_w[g]),
                .envelope  (envelope_w[g]),
                .control   (control_w[g])
            );
        end
        else
        begin : g_off
            assign period_w[g]   = '0;
            assign length_w[g]   = '0;
            assign envelope_w[g] = '0;
            assign control_w[g]  = '0;
        end
    end

    assign status.valid        = out_valid_reg;
    assign status.ch1_period   = period_w[0];
    assign status.ch1_length   = length_w[0];
    assign status.ch1_envelope = envelope_w[0];
    assign status.ch1_control  = control_w[0];
    assign status.ch2_period   = period_w[1];
    assign status.ch2_length   = length_w[1];
    assign status.ch2_envelope = envelope_w[1];
    assign status.ch2_control  = control_w[1];

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_take && in_valid_reg && !advance))
        else $error("item accepted over a pending item");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> status.valid)
        else $error("processed item produced no result");

    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (status.valid && status.ready && !advance) |=> !status.valid)
        else $error("result delivered twice");
`endif

endmodule

// ===== rtl/core/pcs_frame_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_frame_seq - frame sequencer
// Holds the 4/5-step mode and step count and issues the length/sweep and
// envelope strobes on ticks and on frame register writes.
// ----------------------------------------------------------------------------
module pcs_frame_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             op,
    input  logic [4:0]       reg_index,
    input  logic [7:0]       write_data,
    output pcs_pkg::pcs_clk_t strobe
);
    import pcs_pkg::*;

    logic       five_step_reg;
    logic       five_step_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic [3:0] step_inc;

    always_comb
    begin
        five_step_next   = five_step_reg;
        step_next        = step_reg;
        strobe.len_sweep = 1'b0;
        strobe.envelope  = 1'b0;
        step_inc         = {1'b0, step_reg} + 4'd1;
        if (op == OP_TICK)
        begin
            if (five_step_reg)
            begin
                step_next = (step_inc >= 4'd5) ? 3'(step_inc - 4'd5) : step_inc[2:0];
                strobe.len_sweep = (step_next == 3'd1) || (step_next == 3'd3);
                strobe.envelope  = (step_next != 3'd0);
            end
            else
            begin
                step_next = {1'b0, step_inc[1:0]};
                strobe.len_sweep = ~step_next[0];
                strobe.envelope  = 1'b1;
            end
        end
        else if (reg_index == FRAME_REG)
        begin
            five_step_next   = write_data[7];
            step_next        = {2'b10, write_data[7]};
            strobe.len_sweep = write_data[7];
            strobe.envelope  = write_data[7];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            five_step_reg <= 1'b0;
            step_reg      <= 3'd0;
        end
        else if (advance)
        begin
            five_step_reg <= five_step_next;
            step_reg      <= step_next;
        end
    end

endmodule

// ===== rtl/core/pcs_chan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_chan - one pulse channel
// Control, sweep, period and length registers with the length counter,
// sweep unit and envelope, updated once per item.
// ----------------------------------------------------------------------------
module pcs_chan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              neg_extra,
    input  pcs_pkg::pcs_wr_t  wr,
    input  pcs_pkg::pcs_clk_t strobe,
    output logic [15:0]       period,
    output logic [7:0]        length,
    output logic [3:0]        envelope,
    output logic [7:0]        control
);
    import pcs_pkg::*;

    logic [7:0]  control_reg,   control_next;
    logic [7:0]  length_reg,    length_next;
    logic [10:0] raw_reg,       raw_next;
    logic [15:0] eff_reg,       eff_next;
    logic [7:0]  sweep_reg,     sweep_next;
    logic [2:0]  sw_cnt_reg,    sw_cnt_next;
    logic        reload_reg,    reload_next;
    logic        start_reg,     start_next;
    logic [3:0]  env_lvl_reg,   env_lvl_next;
    logic [3:0]  env_cnt_reg,   env_cnt_next;

    logic [10:0] delta;
    logic [11:0] up_sum;
    logic [11:0] sub;
    logic [15:0] dn_diff;
    logic        no_borrow;
    logic        sw_enabled;
    logic [2:0]  sw_period;
    logic        do_apply;

    always_comb
    begin
        delta      = raw_reg >> sweep_reg[2:0];
        up_sum     = {1'b0, raw_reg} + {1'b0, delta};
        sub        = {1'b0, delta} + {11'd0, neg_extra};
        dn_diff    = {5'd0, raw_reg} - {4'd0, sub};
        no_borrow  = ({1'b0, raw_reg} >= sub);
        sw_enabled = sweep_reg[SWEEP_EN_BIT];
        sw_period  = sweep_reg[6:4];

        control_next = control_reg;
        length_next  = length_reg;
        raw_next     = raw_reg;
        eff_next     = eff_reg;
        sweep_next   = sweep_reg;
        sw_cnt_next  = sw_cnt_reg;
        reload_next  = reload_reg;
        start_next   = start_reg;
        env_lvl_next = env_lvl_reg;
        env_cnt_next = env_cnt_reg;
        do_apply     = 1'b0;

        if (wr.en)
        begin
            unique case (wr.sel)
                REG_CONTROL:
                begin
                    control_next = wr.data;
                end
                REG_SWEEP:
                begin
                    sweep_next  = wr.data;
                    reload_next = 1'b1;
                end
                REG_PERIOD_LO:
                begin
                    raw_next = {raw_reg[10:8], wr.data};
                    eff_next = {5'd0, raw_reg[10:8], wr.data};
                end
                REG_LENGTH:
                begin
                    length_next = length_lookup(wr.data[7:3]);
                    raw_next    = {wr.data[2:0], raw_reg[7:0]};
                    eff_next    = {5'd0, wr.data[2:0], raw_reg[7:0]};
                    start_next  = 1'b1;
                end
                default:
                begin
                    control_next = control_reg;
                end
            endcase
        end

        if (strobe.len_sweep)
        begin
            if (!control_reg[CTRL_HALT_BIT] && (length_reg != 8'd0))
                length_next = length_reg - 8'd1;

            if (reload_reg)
            begin
                reload_next = 1'b0;
                sw_cnt_next = sw_period;
                do_apply    = sw_enabled && (sw_cnt_reg == 3'd0);
            end
            else if (sw_enabled)
            begin
                if (sw_cnt_reg != 3'd0)
                begin
                    sw_cnt_next = sw_cnt_reg - 3'd1;
                end
                else
                begin
                    sw_cnt_next = sw_period;
                    do_apply    = 1'b1;
                end
            end

            if (do_apply)
            begin
                if (!sweep_reg[SWEEP_NEG_BIT])
                begin
                    eff_next = {4'd0, up_sum};
                    if (!up_sum[11])
                        raw_next = up_sum[10:0];
                end
                else
                begin
                    eff_next = dn_diff;
                    if (no_borrow && (dn_diff >= MIN_PERIOD))
                        raw_next = dn_diff[10:0];
                end
            end
        end

        if (strobe.envelope)
        begin
            if (start_reg)
            begin
                start_next   = 1'b0;
                env_lvl_next = ENV_FULL;
                env_cnt_next = control_reg[3:0];
            end
            else if (env_cnt_reg != 4'd0)
            begin
                env_cnt_next = env_cnt_reg - 4'd1;
            end
            else
            begin
                env_cnt_next = control_reg[3:0];
                if (env_lvl_reg != 4'd0)
                    env_lvl_next = env_lvl_reg - 4'd1;
                else if (control_reg[CTRL_HALT_BIT])
                    env_lvl_next = ENV_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg <= '0;
            length_reg  <= '0;
            raw_reg     <= '0;
            eff_reg     <= '0;
            sweep_reg   <= '0;
            sw_cnt_reg  <= '0;
            reload_reg  <= 1'b0;
            start_reg   <= 1'b0;
            env_lvl_reg <= '0;
            env_cnt_reg <= '0;
        end
        else if (advance)
        begin
            control_reg <= control_next;
            length_reg  <= length_next;
            raw_reg     <= raw_next;
            eff_reg     <= eff_next;
            sweep_reg   <= sweep_next;
            sw_cnt_reg  <= sw_cnt_next;
            reload_reg  <= reload_next;
            start_reg   <= start_next;
            env_lvl_reg <= env_lvl_next;
            env_cnt_reg <= env_cnt_next;
        end
    end

    assign period   = eff_reg;
    assign length   = length_reg;
    assign envelope = env_lvl_reg;
    assign control  = control_reg;

endmodule
